@@ hw/rtl/drd_pkg.sv @@
`timescale 1ns / 1ps
package drd_pkg;

  localparam int MAX_ROOMS_DEF = 16;
  localparam int CFG_W         = 5;
  localparam int IN_TIME_W     = 32;
  localparam int TIME_W        = 48;
  localparam int COUNT_W       = 32;
  localparam int ROOM_W        = 4;

  localparam logic [CFG_W-1:0] ROOM_COUNT_RST = 5'd16;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic cmp_en;
    logic cmp_first;
    logic upd;
    logic cnt;
    logic push;
  } drd_cmd_t;

endpackage

@@ hw/rtl/drd_ctrl.sv @@
`timescale 1ns / 1ps
module drd_ctrl #(
  parameter int MAX_ROOMS = drd_pkg::MAX_ROOMS_DEF,
  localparam int RW = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [drd_pkg::CFG_W-1:0] cfg_wr_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  output logic                     out_valid,
  input  logic                     out_stall,
  output drd_pkg::drd_cmd_t        cmd,
  output logic [RW-1:0]            rd_idx,
  output logic [RW-1:0]            cmp_idx
);
  import drd_pkg::*;

  localparam int NW = $clog2(MAX_ROOMS + 1);
  localparam int CW = (NW > CFG_W) ? NW : CFG_W;

  typedef enum logic [2:0] {
    IDLE,
    SCAN,
    DRAIN,
    UPD,
    CNT,
    PUSH
  } state_t;

  state_t           state_r, state_nxt;
  logic [CFG_W-1:0] room_count_r, room_count_nxt;
  logic [RW-1:0]    rd_idx_r, rd_idx_nxt;
  logic [RW-1:0]    cmp_idx_r, cmp_idx_nxt;
  logic             cmp_en_r, cmp_en_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic [CW-1:0]    cfg_ext;
  logic [CW-1:0]    act;
  logic [CW-1:0]    act_m1;
  logic [RW-1:0]    last_idx;
  logic             accept;
  logic             out_free;

  always_comb begin
    cfg_ext = CW'(room_count_r);
    if (cfg_ext == '0) begin
      act = CW'(1);
    end else if (cfg_ext > CW'(MAX_ROOMS)) begin
      act = CW'(MAX_ROOMS);
    end else begin
      act = cfg_ext;
    end
    act_m1   = act - CW'(1);
    last_idx = act_m1[RW-1:0];
  end

  assign accept   = in_valid && (state_r == IDLE);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt      = state_r;
    room_count_nxt = room_count_r;
    rd_idx_nxt     = rd_idx_r;
    cmp_idx_nxt    = rd_idx_r;
    cmp_en_nxt     = (state_r == SCAN);
    out_valid_nxt  = out_valid_r;
    if (cfg_wr_en) begin
      room_count_nxt = cfg_wr_data;
    end
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      IDLE: begin
        if (accept) begin
          state_nxt  = SCAN;
          rd_idx_nxt = '0;
        end
      end
      SCAN: begin
        if (rd_idx_r == last_idx) begin
          state_nxt = DRAIN;
        end else begin
          rd_idx_nxt = rd_idx_r + RW'(1);
        end
      end
      DRAIN: state_nxt = UPD;
      UPD:   state_nxt = CNT;
      CNT:   state_nxt = PUSH;
      PUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = IDLE;
        end
      end
      default: state_nxt = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= IDLE;
      room_count_r <= ROOM_COUNT_RST;
      rd_idx_r     <= '0;
      cmp_idx_r    <= '0;
      cmp_en_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      room_count_r <= room_count_nxt;
      rd_idx_r     <= rd_idx_nxt;
      cmp_idx_r    <= cmp_idx_nxt;
      cmp_en_r     <= cmp_en_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_comb begin
    cmd.load      = accept;
    cmd.rd_en     = (state_r == SCAN);
    cmd.cmp_en    = cmp_en_r;
    cmd.cmp_first = (cmp_idx_r == '0);
    cmd.upd       = (state_r == UPD);
    cmd.cnt       = (state_r == CNT);
    cmd.push      = (state_r == PUSH) && out_free;
  end

  assign in_stall  = (state_r != IDLE);
  assign out_valid = out_valid_r;
  assign rd_idx    = rd_idx_r;
  assign cmp_idx   = cmp_idx_r;

  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.rd_en, cmd.upd, cmd.cnt, cmd.push}))
    else $error("drd_ctrl: overlapping datapath commands");

  a_upd_after_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == UPD) |-> $past(cmp_en_r))
    else $error("drd_ctrl: update without a final compare");

  a_out_from_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == PUSH))
    else $error("drd_ctrl: result raised outside push");

endmodule

@@ hw/rtl/drd_dpath.sv @@
`timescale 1ns / 1ps
module drd_dpath #(
  parameter int MAX_ROOMS = drd_pkg::MAX_ROOMS_DEF,
  localparam int RW = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  drd_pkg::drd_cmd_t             cmd,
  input  logic [RW-1:0]                 rd_idx,
  input  logic [RW-1:0]                 cmp_idx,
  input  logic                          in_new_batch,
  input  logic [drd_pkg::IN_TIME_W-1:0] in_start_time,
  input  logic [drd_pkg::IN_TIME_W-1:0] in_end_time,
  output logic [drd_pkg::ROOM_W-1:0]    out_assigned_room,
  output logic [drd_pkg::TIME_W-1:0]    out_actual_begin,
  output logic [drd_pkg::TIME_W-1:0]    out_actual_finish,
  output logic [drd_pkg::ROOM_W-1:0]    out_most_booked_room
);
  import drd_pkg::*;

  logic [TIME_W-1:0]    free_mem [MAX_ROOMS];
  logic [COUNT_W-1:0]   cnt_mem  [MAX_ROOMS];
  logic [MAX_ROOMS-1:0] free_vld_r;
  logic [MAX_ROOMS-1:0] cnt_vld_r;

  logic [IN_TIME_W-1:0] start_r;
  logic [IN_TIME_W-1:0] dur_r;
  logic [TIME_W-1:0]    free_rd_r;
  logic                 free_rv_r;
  logic [COUNT_W-1:0]   cnt_rd_r;
  logic                 cnt_rv_r;

  logic                 found_r;
  logic [RW-1:0]        found_idx_r;
  logic [RW-1:0]        early_idx_r;
  logic [TIME_W-1:0]    early_val_r;

  logic [RW-1:0]        room_r;
  logic [TIME_W-1:0]    begin_r;
  logic [TIME_W-1:0]    finish_r;
  logic [RW-1:0]        best_room_r;
  logic [COUNT_W-1:0]   best_cnt_r;

  logic [ROOM_W-1:0]    out_room_r;
  logic [TIME_W-1:0]    out_begin_r;
  logic [TIME_W-1:0]    out_finish_r;
  logic [ROOM_W-1:0]    out_best_r;

  logic                 clear;
  logic [TIME_W-1:0]    free_val;
  logic [TIME_W-1:0]    start_ext;
  logic [RW-1:0]        sel_room;
  logic [TIME_W-1:0]    sel_begin;
  logic [TIME_W:0]      sel_sum;
  logic [TIME_W-1:0]    sel_finish;
  logic [COUNT_W-1:0]   cnt_old;
  logic [COUNT_W-1:0]   cnt_new;
  logic                 better;
  logic [RW+ROOM_W-1:0] room_wide;
  logic [RW+ROOM_W-1:0] best_wide;

  assign clear     = cmd.load && in_new_batch;
  assign free_val  = free_rv_r ? free_rd_r : '0;
  assign start_ext = TIME_W'(start_r);

  always_comb begin
    sel_room   = found_r ? found_idx_r : early_idx_r;
    sel_begin  = found_r ? start_ext : early_val_r;
    sel_sum    = {1'b0, sel_begin} + (TIME_W + 1)'(dur_r);
    sel_finish = sel_sum[TIME_W] ? '1 : sel_sum[TIME_W-1:0];
    cnt_old    = cnt_rv_r ? cnt_rd_r : '0;
    cnt_new    = (cnt_old == '1) ? cnt_old : cnt_old + COUNT_W'(1);
    better     = (cnt_new > best_cnt_r) ||
                 ((cnt_new == best_cnt_r) && (room_r < best_room_r));
    room_wide  = {{ROOM_W{1'b0}}, room_r};
    best_wide  = {{ROOM_W{1'b0}}, best_room_r};
  end

  // hold the job and its duration
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      start_r <= in_start_time;
      dur_r   <= (in_end_time > in_start_time) ? in_end_time - in_start_time : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      free_rd_r <= free_mem[rd_idx];
      free_rv_r <= free_vld_r[rd_idx];
    end
    if (cmd.upd) begin
      free_mem[sel_room] <= sel_finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      cnt_rd_r <= cnt_mem[sel_room];
      cnt_rv_r <= cnt_vld_r[sel_room];
    end
    if (cmd.cnt) begin
      cnt_mem[room_r] <= cnt_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_vld_r  <= '0;
      cnt_vld_r   <= '0;
      best_room_r <= '0;
      best_cnt_r  <= '0;
      found_r     <= 1'b0;
    end else begin
      if (clear) begin
        free_vld_r  <= '0;
        cnt_vld_r   <= '0;
        best_room_r <= '0;
        best_cnt_r  <= '0;
      end
      if (cmd.load) begin
        found_r <= 1'b0;
      end else if (cmd.cmp_en && !found_r && (free_val <= start_ext)) begin
        found_r <= 1'b1;
      end
      if (cmd.upd) begin
        free_vld_r[sel_room] <= 1'b1;
      end
      if (cmd.cnt) begin
        cnt_vld_r[room_r] <= 1'b1;
        best_cnt_r        <= better ? cnt_new : best_cnt_r;
        best_room_r       <= better ? room_r : best_room_r;
      end
    end
  end

  // track first free room and earliest release
  always_ff @(posedge clk) begin
    if (cmd.cmp_en) begin
      if (!found_r && (free_val <= start_ext)) begin
        found_idx_r <= cmp_idx;
      end
      if (cmd.cmp_first || (free_val < early_val_r)) begin
        early_idx_r <= cmp_idx;
        early_val_r <= free_val;
      end
    end
    if (cmd.upd) begin
      room_r   <= sel_room;
      begin_r  <= sel_begin;
      finish_r <= sel_finish;
    end
    if (cmd.push) begin
      out_room_r   <= room_wide[ROOM_W-1:0];
      out_begin_r  <= begin_r;
      out_finish_r <= finish_r;
      out_best_r   <= best_wide[ROOM_W-1:0];
    end
  end

  assign out_assigned_room    = out_room_r;
  assign out_actual_begin     = out_begin_r;
  assign out_actual_finish    = out_finish_r;
  assign out_most_booked_room = out_best_r;

  a_finish_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd |=> (finish_r >= begin_r))
    else $error("drd_dpath: finish before begin");

  a_best_booked: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt |=> (best_cnt_r != '0))
    else $error("drd_dpath: best count empty after a booking");

  a_found_held: assert property (@(posedge clk) disable iff (!rst_n)
    (found_r && !cmd.load) |=> found_r)
    else $error("drd_dpath: found flag dropped inside a job");

endmodule

@@ hw/rtl/delayed_resource_dispatcher.sv @@
`timescale 1ns / 1ps
// Assigns each job to the lowest-numbered resource that is free by its start time, or,
// when none is, to the resource that frees first (lowest index on ties), starting the
// job at its free time with the job's own duration. Jobs must come in nondecreasing
// start order within a batch; in_new_batch clears all free times and booking counts
// first. One job is handled at a time: the block scans the free-time memory one entry
// per cycle, then drains, updates, counts and pushes, waiting in push while the last
// result is stalled. No clearing pass is needed after reset. Write cfg_wr_data only
// while the block is idle; 0 acts as 1 and values above MAX_ROOMS act as MAX_ROOMS.
module delayed_resource_dispatcher #(
  parameter int MAX_ROOMS = drd_pkg::MAX_ROOMS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [drd_pkg::CFG_W-1:0]     cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_new_batch,
  input  logic [drd_pkg::IN_TIME_W-1:0] in_start_time,
  input  logic [drd_pkg::IN_TIME_W-1:0] in_end_time,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [drd_pkg::ROOM_W-1:0]    out_assigned_room,
  output logic [drd_pkg::TIME_W-1:0]    out_actual_begin,
  output logic [drd_pkg::TIME_W-1:0]    out_actual_finish,
  output logic [drd_pkg::ROOM_W-1:0]    out_most_booked_room
);
  import drd_pkg::*;

  localparam int RW = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;

  drd_cmd_t      cmd;
  logic [RW-1:0] rd_idx;
  logic [RW-1:0] cmp_idx;

  drd_ctrl #(
    .MAX_ROOMS (MAX_ROOMS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cmd         (cmd),
    .rd_idx      (rd_idx),
    .cmp_idx     (cmp_idx)
  );

  drd_dpath #(
    .MAX_ROOMS (MAX_ROOMS)
  ) u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .rd_idx               (rd_idx),
    .cmp_idx              (cmp_idx),
    .in_new_batch         (in_new_batch),
    .in_start_time        (in_start_time),
    .in_end_time          (in_end_time),
    .out_assigned_room    (out_assigned_room),
    .out_actual_begin     (out_actual_begin),
    .out_actual_finish    (out_actual_finish),
    .out_most_booked_room (out_most_booked_room)
  );

endmodule

@@ tb/tb_delayed_resource_dispatcher.sv @@
`timescale 1ns / 1ps
module tb_delayed_resource_dispatcher;

  localparam int NR       = drd_pkg::MAX_ROOMS_DEF;
  localparam int TW       = drd_pkg::TIME_W;
  localparam int STUCK_MAX = 4000;
  localparam int PER_PHASE = 154;

  typedef struct packed {
    logic [drd_pkg::ROOM_W-1:0] room;
    logic [TW-1:0]              t_begin;
    logic [TW-1:0]              t_finish;
    logic [drd_pkg::ROOM_W-1:0] top_room;
  } dispatch_t;

  typedef struct {
    int                          cfg;
    logic                        nb;
    logic [drd_pkg::IN_TIME_W-1:0] st;
    logic [drd_pkg::IN_TIME_W-1:0] et;
    logic                        typed;
    dispatch_t                   want;
  } job_row_t;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_wr_en;
  logic [drd_pkg::CFG_W-1:0]       cfg_wr_data;
  logic                            in_valid;
  logic                            in_stall;
  logic                            in_new_batch;
  logic [drd_pkg::IN_TIME_W-1:0]   in_start_time;
  logic [drd_pkg::IN_TIME_W-1:0]   in_end_time;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [drd_pkg::ROOM_W-1:0]      out_assigned_room;
  logic [TW-1:0]                   out_actual_begin;
  logic [TW-1:0]                   out_actual_finish;
  logic [drd_pkg::ROOM_W-1:0]      out_most_booked_room;

  delayed_resource_dispatcher u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_new_batch         (in_new_batch),
    .in_start_time        (in_start_time),
    .in_end_time          (in_end_time),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_assigned_room    (out_assigned_room),
    .out_actual_begin     (out_actual_begin),
    .out_actual_finish    (out_actual_finish),
    .out_most_booked_room (out_most_booked_room)
  );

  // scheduler state mirror
  logic [TW-1:0]                free_at [NR];
  logic [drd_pkg::COUNT_W-1:0]  booked  [NR];
  logic [drd_pkg::ROOM_W-1:0]   leader;
  logic [drd_pkg::CFG_W-1:0]    rooms_cfg;

  dispatch_t pending_dispatch [$];
  job_row_t  job_table [$];

  int snd_idle_pct;
  int rcv_idle_pct;
  int n_errors;
  int n_jobs;
  int n_batches;
  int n_results;
  int n_cfg;
  int stuck;
  logic [31:0] batch_clock;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH %s", msg);
    n_errors++;
  endtask

  function automatic int active_rooms();
    if (rooms_cfg == 0) return 1;
    if (rooms_cfg > NR) return NR;
    return int'(rooms_cfg);
  endfunction

  function automatic void predict_dispatch(input logic nb, input logic [31:0] st,
                                           input logic [31:0] et, output dispatch_t r);
    logic [TW-1:0] dur;
    logic [TW-1:0] t0;
    logic [TW:0]   sum;
    int            n;
    int            pick;
    int            early;
    bit            found;
    dur = (et > st) ? {16'd0, et - st} : '0;
    if (nb) begin
      for (int i = 0; i < NR; i++) begin
        free_at[i] = '0;
        booked[i]  = '0;
      end
      leader = '0;
    end
    n = active_rooms();
    found = 1'b0;
    pick  = 0;
    early = 0;
    for (int i = 0; i < n; i++) begin
      if (!found && free_at[i] <= {16'd0, st}) begin
        pick  = i;
        found = 1'b1;
      end
      if (free_at[i] < free_at[early]) early = i;
    end
    if (found) begin
      t0 = {16'd0, st};
    end else begin
      pick = early;
      t0   = free_at[early];
    end
    sum = {1'b0, t0} + {1'b0, dur};
    r.t_finish = sum[TW] ? '1 : sum[TW-1:0];
    r.t_begin  = t0;
    r.room     = pick[drd_pkg::ROOM_W-1:0];
    free_at[pick] = r.t_finish;
    if (booked[pick] != '1) booked[pick] = booked[pick] + 32'd1;
    if (booked[pick] > booked[leader] ||
        (booked[pick] == booked[leader] && pick < int'(leader)))
      leader = pick[drd_pkg::ROOM_W-1:0];
    r.top_room = leader;
  endfunction

  task automatic add_row(input int cfg, input logic nb, input logic [31:0] st,
                         input logic [31:0] et, input logic typed, input int room,
                         input logic [TW-1:0] b, input logic [TW-1:0] f, input int top);
    job_row_t row;
    row.cfg   = cfg;
    row.nb    = nb;
    row.st    = st;
    row.et    = et;
    row.typed = typed;
    row.want.room     = room[drd_pkg::ROOM_W-1:0];
    row.want.t_begin  = b;
    row.want.t_finish = f;
    row.want.top_room = top[drd_pkg::ROOM_W-1:0];
    job_table.push_back(row);
  endtask

  task automatic write_rooms(input logic [drd_pkg::CFG_W-1:0] v);
    in_valid <= 1'b0;
    while (pending_dispatch.size() != 0) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    rooms_cfg = v;
    n_cfg++;
  endtask

  task automatic drive_job(input logic nb, input logic [31:0] st, input logic [31:0] et,
                           input logic typed, input dispatch_t want);
    dispatch_t pred;
    if ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_new_batch  <= nb;
    in_start_time <= st;
    in_end_time   <= et;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_dispatch(nb, st, et, pred);
    pending_dispatch.push_back(typed ? want : pred);
    n_jobs++;
    if (nb) n_batches++;
  endtask

  task automatic random_job();
    logic [31:0] st;
    logic [31:0] et;
    logic [32:0] nxt;
    logic        nb;
    int          pick;
    int          d;
    pick = $urandom_range(0, 99);
    nb   = 1'b0;
    if (pick < 4) begin
      nb = 1'b1;
      batch_clock = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1000);
      st = batch_clock;
    end else if (pick < 10) begin
      nb = $urandom_range(0, 1);
      st = $urandom;
    end else begin
      nxt = {1'b0, batch_clock} + 33'($urandom_range(0, 6));
      if (nxt[32]) begin
        nb = 1'b1;
        batch_clock = $urandom_range(0, 1000);
      end else begin
        batch_clock = nxt[31:0];
      end
      st = batch_clock;
    end
    d = $urandom_range(0, 99);
    if (pick >= 4 && pick < 10) begin
      et = $urandom;
    end else if (d < 80) begin
      nxt = {1'b0, st} + 33'($urandom_range(1, 12 * active_rooms()));
      et  = nxt[32] ? 32'hFFFF_FFFF : nxt[31:0];
    end else if (d < 90) begin
      et = (st >= 5) ? st - $urandom_range(0, 5) : st;
    end else begin
      et = $urandom;
    end
    drive_job(nb, st, et, 1'b0, '0);
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
  end

  always @(posedge clk) begin : mon
    dispatch_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_dispatch.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing pending, room %0d",
                                    out_assigned_room));
        end else begin
          want = pending_dispatch.pop_front();
          if (out_assigned_room !== want.room)
            report_mismatch($sformatf("result %0d room got %0d want %0d",
                                      n_results, out_assigned_room, want.room));
          if (out_actual_begin !== want.t_begin)
            report_mismatch($sformatf("result %0d begin got %0h want %0h",
                                      n_results, out_actual_begin, want.t_begin));
          if (out_actual_finish !== want.t_finish)
            report_mismatch($sformatf("result %0d finish got %0h want %0h",
                                      n_results, out_actual_finish, want.t_finish));
          if (out_most_booked_room !== want.top_room)
            report_mismatch($sformatf("result %0d most booked got %0d want %0d",
                                      n_results, out_most_booked_room, want.top_room));
        end
        n_results++;
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) stuck = 0;
      else stuck++;
      if (stuck >= STUCK_MAX) begin
        $display("watchdog: no beat for %0d cycles, %0d pending", stuck,
                 pending_dispatch.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    logic [drd_pkg::CFG_W-1:0] v;
    rst_n         <= 1'b0;
    cfg_wr_en     <= 1'b0;
    cfg_wr_data   <= '0;
    in_valid      <= 1'b0;
    in_new_batch  <= 1'b0;
    in_start_time <= '0;
    in_end_time   <= '0;
    n_errors  = 0;
    n_jobs    = 0;
    n_batches = 0;
    n_results = 0;
    n_cfg     = 0;
    stuck     = 0;
    batch_clock = '0;
    snd_idle_pct = 13;
    rcv_idle_pct = 53;
    rooms_cfg = drd_pkg::ROOM_COUNT_RST;
    for (int i = 0; i < NR; i++) begin
      free_at[i] = '0;
      booked[i]  = '0;
    end
    leader = '0;

    add_row(-1, 1, 0, 10, 1, 0, 0, 10, 0);
    add_row(-1, 0, 0, 5, 1, 1, 0, 5, 0);
    add_row(-1, 0, 5, 5, 1, 1, 5, 5, 1);
    add_row(-1, 0, 7, 3, 1, 1, 7, 7, 1);
    add_row(-1, 1, 32'hFFFF_FFFF, 0, 1, 0, 48'hFFFF_FFFF, 48'hFFFF_FFFF, 0);
    add_row(-1, 1, 0, 32'hFFFF_FFFF, 1, 0, 0, 48'hFFFF_FFFF, 0);
    add_row(1, 1, 100, 200, 1, 0, 100, 200, 0);
    add_row(-1, 0, 100, 150, 1, 0, 200, 250, 0);
    add_row(-1, 0, 120, 32'hFFFF_FFFF, 0, 0, 0, 0, 0);
    add_row(0, 1, 5, 9, 1, 0, 5, 9, 0);
    add_row(-1, 0, 6, 8, 1, 0, 9, 11, 0);
    add_row(31, 1, 0, 4, 1, 0, 0, 4, 0);
    add_row(-1, 0, 0, 4, 1, 1, 0, 4, 0);
    add_row(-1, 0, 4, 6, 1, 0, 4, 6, 0);
    add_row(3, 1, 0, 10, 1, 0, 0, 10, 0);
    add_row(-1, 0, 0, 10, 1, 1, 0, 10, 0);
    add_row(-1, 0, 0, 5, 1, 2, 0, 5, 0);
    add_row(-1, 0, 5, 6, 1, 2, 5, 6, 2);
    add_row(-1, 0, 6, 7, 0, 0, 0, 0, 0);
    add_row(-1, 0, 6, 9, 0, 0, 0, 0, 0);
    add_row(2, 0, 20, 25, 1, 0, 20, 25, 2);
    add_row(16, 0, 20, 21, 0, 0, 0, 0, 0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (job_table[i]) begin
      if (job_table[i].cfg >= 0) write_rooms(job_table[i].cfg[drd_pkg::CFG_W-1:0]);
      drive_job(job_table[i].nb, job_table[i].st, job_table[i].et, job_table[i].typed,
                job_table[i].want);
    end

    for (int mode = 0; mode < 3; mode++) begin
      snd_idle_pct = (mode == 0) ? 13 : (mode == 1) ? 53 : 0;
      rcv_idle_pct = (mode == 0) ? 53 : (mode == 1) ? 13 : 0;
      for (int sub = 0; sub < 4; sub++) begin
        if (sub == 0) v = (mode == 0) ? 5'd16 : (mode == 1) ? 5'd1 : 5'd31;
        else v = 5'($urandom_range(0, 31));
        write_rooms(v);
        repeat (PER_PHASE) random_job();
      end
    end

    in_valid <= 1'b0;
    while (pending_dispatch.size() != 0) @(posedge clk);
    repeat (NR + 10) @(posedge clk);
    if (pending_dispatch.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_dispatch.size()));

    $display("ran %0d jobs in %0d batches across %0d room-count writes, including delays",
             n_jobs, n_batches, n_cfg);
    $display("checked %0d result beats, %0d mismatches", n_results, n_errors);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ delayed_resource_dispatcher.f @@
hw/rtl/drd_pkg.sv
hw/rtl/drd_ctrl.sv
hw/rtl/drd_dpath.sv
hw/rtl/delayed_resource_dispatcher.sv
tb/tb_delayed_resource_dispatcher.sv
